// ===== rtl/core/mur64a_pkg.sv =====
// ----------------------------------------------------------------------------
// mur64a_pkg: shared types and constants for the MurmurHash64A block
// Mixing constant, command/status structs between controller and datapath,
// controller state encoding and small helper functions.
// ----------------------------------------------------------------------------
package mur64a_pkg;

    // Mixing multiplier and shift
    localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MUR_M_LO = MUR_M[31:0];
    localparam logic [31:0] MUR_M_HI = MUR_M[63:32];
    localparam int          MUR_R    = 47;

    // A 64x64 multiply by M (low 64 bits) runs as three 32x32 partial
    // products plus one final accumulate: steps 1..MUL_STEPS
    localparam int          STEP_W    = 3;
    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(4);

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_SEED,
        ST_ROUTE,
        ST_K1,
        ST_K2,
        ST_FOLD,
        ST_TAIL,
        ST_HUPD,
        ST_AV,
        ST_OUT
    } state_t;

    // Partial product select
    typedef enum logic [1:0] {
        MUL_LL,
        MUL_LH,
        MUL_HL
    } mul_sel_t;

    // Product accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_HI
    } acc_op_t;

    // Multiplicand register source
    typedef enum logic [2:0] {
        X_HOLD,
        X_LEN,
        X_WORD,
        X_MIX,
        X_FOLD,
        X_TAIL,
        X_AVAL
    } x_src_t;

    // Running hash register source
    typedef enum logic [1:0] {
        H_HOLD,
        H_INIT,
        H_ACC,
        H_FIN
    } h_src_t;

    // Controller -> datapath
    typedef struct packed {
        logic     capture;
        x_src_t   x_src;
        h_src_t   h_src;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     out_load;
    } dp_cmd_t;

    // Datapath -> controller, from the captured word
    typedef struct packed {
        logic last;
        logic full;
        logic empty;
    } dp_sts_t;

    // v ^ (v >> R)
    function automatic logic [63:0] xor_shift(input logic [63:0] v);
        return v ^ (v >> MUR_R);
    endfunction

    // Byte mask keeping the low n bytes
    function automatic logic [63:0] tail_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (n > 4'(i)) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/mur64a_dpath.sv =====
// ----------------------------------------------------------------------------
// mur64a_dpath: MurmurHash64A datapath
// Holds the captured word, seed, running hash, multiplicand and product
// accumulator, and a single shared 32x32 multiplier with registered output.
// ----------------------------------------------------------------------------
module mur64a_dpath
    import mur64a_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // seed write
    input  logic        seed_we,
    input  logic [63:0] seed_wdata,
    // input word
    input  logic [63:0] in_data_word,
    input  logic [3:0]  in_bytes_valid,
    input  logic [31:0] in_message_length,
    input  logic        in_last_word,
    // control
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    output logic [63:0] hash_value
);

    logic [63:0] seed_reg;
    logic [63:0] word_reg;
    logic [3:0]  nvalid_reg;
    logic [31:0] len_reg;
    logic        last_reg;
    logic [63:0] x_reg,    x_next;
    logic [63:0] h_reg,    h_next;
    logic [63:0] acc_reg,  acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] hash_out_reg;
    logic [31:0] mul_a, mul_b;

    // Seed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (seed_we) begin
            seed_reg <= seed_wdata;
        end
    end

    // Capture the accepted word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            word_reg   <= in_data_word;
            nvalid_reg <= in_bytes_valid;
            len_reg    <= in_message_length;
            last_reg   <= in_last_word;
        end
    end

    assign sts.last  = last_reg;
    assign sts.full  = nvalid_reg[3];
    assign sts.empty = (nvalid_reg == 4'd0);

    // Partial product operand select
    always_comb begin
        case (cmd.mul_sel)
            MUL_LL: begin
                mul_a = x_reg[31:0];
                mul_b = MUR_M_LO;
            end
            MUL_LH: begin
                mul_a = x_reg[31:0];
                mul_b = MUR_M_HI;
            end
            MUL_HL: begin
                mul_a = x_reg[63:32];
                mul_b = MUR_M_LO;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};

    // Accumulator: low product loads, cross products add into the upper half
    always_comb begin
        case (cmd.acc_op)
            ACC_LOAD:   acc_next = prod_reg;
            ACC_ADD_HI: acc_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
            default:    acc_next = acc_reg;
        endcase
    end

    // Multiplicand source
    always_comb begin
        case (cmd.x_src)
            X_LEN:   x_next = {32'd0, len_reg};
            X_WORD:  x_next = word_reg;
            X_MIX:   x_next = xor_shift(acc_reg);
            X_FOLD:  x_next = h_reg ^ acc_reg;
            X_TAIL:  x_next = h_reg ^ (word_reg & tail_mask(nvalid_reg));
            X_AVAL:  x_next = xor_shift(h_reg);
            default: x_next = x_reg;
        endcase
    end

    // Running hash source
    always_comb begin
        case (cmd.h_src)
            H_INIT:  h_next = seed_reg ^ acc_reg;
            H_ACC:   h_next = acc_reg;
            H_FIN:   h_next = xor_shift(acc_reg);
            default: h_next = h_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg <= '0;
        end else begin
            h_reg <= h_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        if (cmd.out_load) begin
            hash_out_reg <= h_next;
        end
    end

    assign hash_value = hash_out_reg;

endmodule

// ===== rtl/core/mur64a_ctrl.sv =====
// ----------------------------------------------------------------------------
// mur64a_ctrl: MurmurHash64A controller
// Sequences each word through the shared multiplier, tracks message state
// and owns the input ready and result valid.
// ----------------------------------------------------------------------------
module mur64a_ctrl
    import mur64a_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    s_first_word,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   cnt_reg,   cnt_next;
    logic                in_msg_reg, in_msg_next;
    logic                m_valid_reg, m_valid_next;
    logic                mul_state;
    logic                mul_done;
    state_t              route_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            in_msg_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            in_msg_reg  <= in_msg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    assign mul_state = (state_reg == ST_LEN) || (state_reg == ST_K1) ||
                       (state_reg == ST_K2) || (state_reg == ST_FOLD) ||
                       (state_reg == ST_TAIL) || (state_reg == ST_AV);

    // Where a word goes once the hash start value is in place
    always_comb begin
        if (!sts.last || sts.full) begin
            route_state = ST_K1;
        end else if (!sts.empty) begin
            route_state = ST_TAIL;
        end else begin
            route_state = ST_AV;
        end
    end

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        in_msg_next  = in_msg_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        mul_done     = 1'b0;

        cmd.capture  = 1'b0;
        cmd.x_src    = X_HOLD;
        cmd.h_src    = H_HOLD;
        cmd.mul_sel  = MUL_LL;
        cmd.acc_op   = ACC_HOLD;
        cmd.out_load = 1'b0;

        // multiply steps, shared by every multiply state
        if (mul_state && (cnt_reg != '0)) begin
            case (cnt_reg)
                STEP_W'(1): begin
                    cmd.mul_sel = MUL_LL;
                end
                STEP_W'(2): begin
                    cmd.mul_sel = MUL_LH;
                    cmd.acc_op  = ACC_LOAD;
                end
                STEP_W'(3): begin
                    cmd.mul_sel = MUL_HL;
                    cmd.acc_op  = ACC_ADD_HI;
                end
                default: begin
                    cmd.acc_op  = ACC_ADD_HI;
                end
            endcase
            if (cnt_reg == MUL_STEPS) begin
                cnt_next = '0;
                mul_done = 1'b1;
            end else begin
                cnt_next = cnt_reg + STEP_W'(1);
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_first_word) begin
                        state_next  = ST_LEN;
                        in_msg_next = 1'b1;
                    end else if (in_msg_reg) begin
                        state_next  = ST_ROUTE;
                    end
                end
            end
            ST_LEN: begin
                if (cnt_reg == '0) begin
                    cmd.x_src = X_LEN;
                    cnt_next  = STEP_W'(1);
                end else if (mul_done) begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED: begin
                cmd.h_src  = H_INIT;
                state_next = route_state;
            end
            ST_ROUTE: begin
                state_next = route_state;
            end
            ST_K1: begin
                if (cnt_reg == '0) begin
                    cmd.x_src = X_WORD;
                    cnt_next  = STEP_W'(1);
                end else if (mul_done) begin
                    state_next = ST_K2;
                end
            end
            ST_K2: begin
                if (cnt_reg == '0) begin
                    cmd.x_src = X_MIX;
                    cnt_next  = STEP_W'(1);
                end else if (mul_done) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (cnt_reg == '0) begin
                    cmd.x_src = X_FOLD;
                    cnt_next  = STEP_W'(1);
                end else if (mul_done) begin
                    state_next = ST_HUPD;
                end
            end
            ST_TAIL: begin
                if (cnt_reg == '0) begin
                    cmd.x_src = X_TAIL;
                    cnt_next  = STEP_W'(1);
                end else if (mul_done) begin
                    state_next = ST_HUPD;
                end
            end
            ST_HUPD: begin
                cmd.h_src  = H_ACC;
                state_next = sts.last ? ST_AV : ST_IDLE;
            end
            ST_AV: begin
                if (cnt_reg == '0) begin
                    cmd.x_src = X_AVAL;
                    cnt_next  = STEP_W'(1);
                end else if (mul_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait until the result register is free or being taken
                if (!m_valid_reg || m_ready) begin
                    cmd.h_src    = H_FIN;
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    in_msg_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/murmur64a_hash.sv =====
// A middle word runs its key multiplies and hash update before the next transfer;
// a first word adds a length multiply and seed load; a last word adds the
// avalanche and result load, and its result is valid as ready returns. A 1..7
// byte tail word uses one multiply in place of three; an unread result holds
// the result load. Each multiply by M runs on one shared 32x32 unit.
// Synchronous reset (aresetn low) clears state, result valid, hash and seed.
// ----------------------------------------------------------------------------
// murmur64a_hash: streaming MurmurHash64A
// Words arrive on the s_ channel, the seed on the cfg channel, and one
// 64-bit hash leaves on the m_ channel per message.
// ----------------------------------------------------------------------------
module murmur64a_hash
    import mur64a_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // seed configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_seed,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_word,
    input  logic [3:0]  s_bytes_valid,
    input  logic [31:0] s_message_length,
    input  logic        s_first_word,
    input  logic        s_last_word,
    // result
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    mur64a_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_first_word (s_first_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    mur64a_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .seed_we           (cfg_valid & cfg_ready),
        .seed_wdata        (cfg_seed),
        .in_data_word      (s_data_word),
        .in_bytes_valid    (s_bytes_valid),
        .in_message_length (s_message_length),
        .in_last_word      (s_last_word),
        .cmd               (cmd),
        .sts               (sts),
        .hash_value        (m_hash_value)
    );

`ifndef SYNTHESIS
    // a result never follows a transfer in the very next cycle
    a_no_fast_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared right after an input transfer");

    // a new result comes out of a busy cycle
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised while the block was idle");

    // the block is ready again as soon as a result is posted
    a_ready_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("block not idle after posting a result");
`endif

endmodule

// ===== test/tb_murmur64a_hash.sv =====
// ----------------------------------------------------------------------------
// tb_murmur64a_hash: self-checking bench for the streaming MurmurHash64A block
// A queue of message words feeds a bursty driver. A monitor keeps its own
// running-hash model, predicts one hash per closed message and compares each
// result transfer in order. Seeds are changed between phases while idle.
// ----------------------------------------------------------------------------
module tb_murmur64a_hash;
    import mur64a_pkg::*;

    localparam int SETTLE_CYCLES  = 64;    // covers the slowest word plus avalanche
    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer
    localparam int PHASE_WORDS    = 100;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic [31:0] length;
        logic        first;
        logic        last;
    } hash_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_seed;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_data_word = '0;
    logic [3:0]  s_bytes_valid = '0;
    logic [31:0] s_message_length = '0;
    logic        s_first_word = 1'b0;
    logic        s_last_word = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_hash_value;

    // word stream waiting for the driver, and hashes waiting for the block
    hash_word_t  word_backlog[$];
    logic [63:0] expected_hashes[$];

    // hash model state
    logic [63:0] seed_model = '0;
    logic [63:0] hash_state = '0;
    logic        msg_open = 1'b0;

    int words_accepted = 0;
    int words_ignored = 0;
    int tails_seen = 0;
    int hashes_checked = 0;
    int mismatches = 0;
    int seeds_written = 0;
    int idle_cycles = 0;

    murmur64a_hash uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_seed         (cfg_seed),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_bytes_valid    (s_bytes_valid),
        .s_message_length (s_message_length),
        .s_first_word     (s_first_word),
        .s_last_word      (s_last_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_hash_value     (m_hash_value)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Hash model
    // ------------------------------------------------------------------

    // mix one full word and fold it into the running hash
    function automatic logic [63:0] fold_in(input logic [63:0] h, input logic [63:0] k);
        logic [63:0] km;
        km = k * MUR_M;
        km = km ^ (km >> MUR_R);
        km = km * MUR_M;
        return (h ^ km) * MUR_M;
    endfunction

    // apply one accepted word; a closed message queues its hash
    task automatic absorb_word(input hash_word_t w);
        logic [63:0] h;
        logic [63:0] mask;
        if (w.first) begin
            hash_state = seed_model ^ (64'(w.length) * MUR_M);
            msg_open = 1'b1;
        end
        if (!msg_open) begin
            words_ignored++;
        end else if (!w.last) begin
            hash_state = fold_in(hash_state, w.data);
        end else begin
            h = hash_state;
            if (w.nbytes >= 4'd8) begin
                h = fold_in(h, w.data);
            end else if (w.nbytes != 4'd0) begin
                // partial tail: keep only the valid low bytes
                mask = (64'd1 << (8 * w.nbytes)) - 64'd1;
                h = (h ^ (w.data & mask)) * MUR_M;
                tails_seen++;
            end
            h = h ^ (h >> MUR_R);
            h = h * MUR_M;
            h = h ^ (h >> MUR_R);
            hash_state = h;
            msg_open = 1'b0;
            expected_hashes.push_back(h);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps
    // ------------------------------------------------------------------
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge aclk) begin
        hash_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (word_backlog.size() > 0) begin
                w = word_backlog.pop_front();
                s_data_word      <= w.data;
                s_bytes_valid    <= w.nbytes;
                s_message_length <= w.length;
                s_first_word     <= w.first;
                s_last_word      <= w.last;
                s_valid          <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern in segments, plus one long hold-off
    // ------------------------------------------------------------------
    int seg_left = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int results_taken = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                results_taken++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && m_valid && results_taken >= 20) begin
                // back-pressure long enough for the block to fill and stall its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(16, 96);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        default: stall_pct = 75;
                    endcase
                end else begin
                    seg_left--;
                end
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: seed writes, word transfers, result check, watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        hash_word_t seen;
        logic [63:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_hashes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected hash result %h", m_hash_value);
                end else begin
                    want = expected_hashes.pop_front();
                    hashes_checked++;
                    if (m_hash_value !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("hash mismatch #%0d: expected %h, got %h",
                                     hashes_checked, want, m_hash_value);
                    end
                end
            end
            if (s_valid && s_ready) begin
                seen.data   = s_data_word;
                seen.nbytes = s_bytes_valid;
                seen.length = s_message_length;
                seen.first  = s_first_word;
                seen.last   = s_last_word;
                words_accepted++;
                absorb_word(seen);
            end
            if (cfg_valid && cfg_ready)
                seed_model = cfg_seed;

            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_word(input logic [63:0] data, input logic [3:0] nbytes,
                              input logic [31:0] length, input logic first,
                              input logic last);
        hash_word_t w;
        w.data   = data;
        w.nbytes = nbytes;
        w.length = length;
        w.first  = first;
        w.last   = last;
        word_backlog.push_back(w);
    endtask

    // wait until every word is in and every hash is out, then let the core settle
    task automatic drain();
        do @(negedge aclk);
        while (word_backlog.size() != 0 || s_valid || expected_hashes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_seed  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        seeds_written++;
        @(negedge aclk);
    endtask

    // mostly well-formed messages; some stray words and cut-off messages
    task automatic random_messages(input int target);
        int count;
        int r;
        int nwords;
        logic [3:0] tail;
        logic [31:0] len;
        bit cut;
        count = 0;
        while (count < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                queue_word(rand_word(), 4'($urandom_range(0, 15)), $urandom, 1'b0,
                           1'($urandom_range(0, 1)));
            end else begin
                nwords = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
                                                     : $urandom_range(1, 5);
                tail = ($urandom_range(0, 2) == 0) ? 4'd8 : 4'($urandom_range(0, 15));
                cut = (r >= 93);
                if ($urandom_range(0, 3) == 0) begin
                    len = $urandom;
                    if (len == 0)
                        len = 1;
                end else begin
                    len = 32'((nwords - 1) * 8 + ((tail == 0) ? 1 : tail));
                end
                for (int i = 0; i < nwords; i++) begin
                    if (i == nwords - 1 && !cut)
                        queue_word(rand_word(), tail, len, i == 0, 1'b1);
                    else
                        queue_word(rand_word(), 4'($urandom_range(0, 15)), len, i == 0, 1'b0);
                end
                count += nwords;
            end
        end
    endtask

    initial begin
        logic [63:0] seeds[6];
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_seed  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words under the reset seed
        // stray words while idle are dropped
        queue_word('1, 4'd8, 32'd8, 1'b0, 1'b0);
        queue_word('1, 4'd3, 32'd8, 1'b0, 1'b1);
        // one-word messages: full, each tail extreme, empty tail, oversized count
        queue_word('1, 4'd8, 32'd8, 1'b1, 1'b1);
        queue_word('1, 4'd1, 32'hffff_ffff, 1'b1, 1'b1);
        queue_word(64'h0, 4'd7, 32'd1, 1'b1, 1'b1);
        queue_word('1, 4'd7, 32'd7, 1'b1, 1'b1);
        queue_word(64'h8000_0000_0000_0001, 4'd0, 32'd1, 1'b1, 1'b1);
        queue_word(64'h0123_4567_89ab_cdef, 4'd15, 32'd8, 1'b1, 1'b1);
        queue_word(64'hfedc_ba98_7654_3210, 4'd9, 32'h8000_0000, 1'b1, 1'b1);
        // three words; counts on inner words are don't-care
        queue_word(64'h5555_5555_5555_5555, 4'd0, 32'd20, 1'b1, 1'b0);
        queue_word(64'haaaa_aaaa_aaaa_aaaa, 4'd15, 32'd20, 1'b0, 1'b0);
        queue_word(64'h1122_3344_5566_7788, 4'd4, 32'd20, 1'b0, 1'b1);
        // a new first word abandons the open message
        queue_word(rand_word(), 4'd8, 32'd24, 1'b1, 1'b0);
        queue_word(rand_word(), 4'd8, 32'd24, 1'b0, 1'b0);
        queue_word(rand_word(), 4'd8, 32'd8, 1'b1, 1'b1);
        // two words ending in a full word, then a two-word message with a 2-byte tail
        queue_word('1, 4'd8, 32'd16, 1'b1, 1'b0);
        queue_word('1, 4'd8, 32'd16, 1'b0, 1'b1);
        queue_word(64'h0, 4'd1, 32'd10, 1'b1, 1'b0);
        queue_word(64'hffff, 4'd2, 32'd10, 1'b0, 1'b1);
        drain();

        // random phases, each under its own seed
        seeds[0] = '1;
        seeds[1] = '0;
        seeds[2] = rand_word();
        seeds[3] = 64'd1;
        seeds[4] = 64'h8000_0000_0000_0000;
        seeds[5] = rand_word();
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            random_messages(PHASE_WORDS);
            drain();
        end

        $display("covered %0d words (%0d dropped while idle, %0d partial tails), %0d seeds",
                 words_accepted, words_ignored, tails_seen, seeds_written);
        $display("checked %0d hashes, %0d left over, %0d mismatches",
                 hashes_checked, expected_hashes.size(), mismatches);
        if (mismatches == 0 && expected_hashes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
